@@ src/bpa_pkg.sv @@
// Package for the bitmap page allocator: field widths, operation codes,
// default parameters and the command/status structs between controller and datapath.
// No dependencies.
package bpa_pkg;

  localparam int MAX_FRAMES_DEF = 32768;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int ADDR_W  = 40;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 16'd32768;

  localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK_USED = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd2;

  typedef struct packed {
    logic in_ready;
    logic clr_write;
    logic scan_start;
    logic scan_step;
    logic alloc_commit;
    logic mark_read;
    logic mark_commit;
    logic res_fail;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            lim_zero;
    logic            in_range;
    logic            found;
    logic            scan_last;
    logic            out_free;
  } dp_sts_t;

endpackage

@@ src/bpa_if.sv @@
// Valid/ready channel interfaces of the bitmap page allocator:
// request words, result words and the limit register write channel.
// Depends on bpa_pkg.
interface bpa_in_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::OP_W-1:0]     op;
  logic [bpa_pkg::ADDR_W-1:0]   req_addr;

  modport source (output valid, output op, output req_addr, input ready);
  modport sink   (input valid, input op, input req_addr, output ready);
endinterface

interface bpa_out_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::ADDR_W-1:0]   alloc_addr;
  logic                         ok;
  logic [bpa_pkg::COUNT_W-1:0]  used_count;

  modport source (output valid, output alloc_addr, output ok, output used_count, input ready);
  modport sink   (input valid, input alloc_addr, input ok, input used_count, output ready);
endinterface

interface bpa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::CFG_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/bpa_ctrl.sv @@
// Controller state machine of the bitmap page allocator.
// Sequences clearing, word scans, marks and result hand-off; depends on bpa_pkg.
module bpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  bpa_pkg::dp_sts_t sts,
  output bpa_pkg::dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_START = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MARK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (sts.op)
          bpa_pkg::OP_ALLOC: begin
            if (sts.lim_zero) begin
              cmd.res_fail = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          bpa_pkg::OP_MARK_USED, bpa_pkg::OP_MARK_FREE: begin
            if (sts.in_range) begin
              cmd.mark_read = 1'b1;
              state_nxt     = S_MARK;
            end else begin
              cmd.res_fail = 1'b1;
              state_nxt    = S_DONE;
            end
          end
          default: begin
            cmd.res_fail = 1'b1;
            state_nxt    = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.found) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = S_DONE;
        end else if (sts.scan_last) begin
          cmd.res_fail = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MARK: begin
        cmd.mark_commit = 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

@@ src/bpa_datapath.sv @@
// Datapath of the bitmap page allocator: bitmap word memory, used-frame count,
// limit register, scan pointers, result and output registers. Depends on bpa_pkg, bpa_if.
module bpa_datapath #(
  parameter int MAX_FRAMES = bpa_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bpa_in_if.sink           in_ch,
  bpa_out_if.source        out_ch,
  bpa_cfg_if.sink          cfg_ch,
  input  bpa_pkg::dp_cmd_t cmd,
  output bpa_pkg::dp_sts_t sts
);

  localparam int WORDS   = (MAX_FRAMES + 31) / 32;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FIDX_W  = WADDR_W + 5;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int PAGE_W  = bpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int CMP_A   = (PAGE_W > CNT_W) ? PAGE_W : CNT_W;
  localparam int CMP_W   = (CMP_A > FIDX_W) ? CMP_A : FIDX_W;
  localparam int LIM_W   = (CNT_W > bpa_pkg::CFG_W) ? CNT_W : bpa_pkg::CFG_W;

  function automatic logic [4:0] low_one(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  idx;
    x   = v;
    idx = '0;
    for (int l = 4; l >= 0; l--) begin
      if ((x & ((32'd1 << (1 << l)) - 32'd1)) == 32'd0) begin
        idx[l] = 1'b1;
        x      = x >> (1 << l);
      end
    end
    return idx;
  endfunction

  logic [31:0] mem [WORDS];
  logic [31:0] rd_data_r;

  logic [bpa_pkg::CFG_W-1:0]  cfg_r, cfg_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [WADDR_W-1:0]         clr_ptr_r, clr_ptr_nxt;
  logic [WADDR_W:0]           iss_ptr_r;
  logic [WADDR_W-1:0]         chk_ptr_r;
  logic [bpa_pkg::OP_W-1:0]   op_r;
  logic [CMP_W-1:0]           page_r;
  logic [bpa_pkg::ADDR_W-1:0] res_addr_r;
  logic                       res_ok_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [bpa_pkg::ADDR_W-1:0] out_addr_r;
  logic                       out_ok_r;
  logic [bpa_pkg::COUNT_W-1:0] out_count_r;

  logic [LIM_W-1:0]   lim_wide;
  logic [LIM_W-1:0]   max_wide;
  logic [CNT_W-1:0]   lim;
  logic [CMP_W-1:0]   lim_ext;
  logic [CMP_W-1:0]   chk_ext;
  logic [31:0]        vmask;
  logic [31:0]        free_bits;
  logic [4:0]         enc;
  logic [FIDX_W-1:0]  alloc_frame;
  logic [63:0]        alloc_wide;
  logic [WADDR_W-1:0] mark_word_idx;
  logic [31:0]        mark_onehot;
  logic               mark_tgt;
  logic               mark_flip;
  logic [31:0]        mark_word;
  logic               in_load;
  logic               out_free;
  logic               we;
  logic [WADDR_W-1:0] wa;
  logic [31:0]        wd;
  logic               re;
  logic [WADDR_W-1:0] ra;

  assign lim_wide = LIM_W'(cfg_r);
  assign max_wide = LIM_W'(MAX_FRAMES);
  assign lim      = CNT_W'((lim_wide > max_wide) ? max_wide : lim_wide);
  assign lim_ext  = CMP_W'(lim);
  assign chk_ext  = CMP_W'(chk_ptr_r);

  assign vmask       = (chk_ext < (lim_ext >> 5)) ? '1 : ((32'd1 << lim_ext[4:0]) - 32'd1);
  assign free_bits   = ~rd_data_r & vmask;
  assign enc         = low_one(free_bits);
  assign alloc_frame = {chk_ptr_r, enc};
  assign alloc_wide  = 64'(alloc_frame) << PAGE_SHIFT;

  assign mark_word_idx = page_r[FIDX_W-1:5];
  assign mark_onehot   = 32'd1 << page_r[4:0];
  assign mark_tgt      = (op_r == bpa_pkg::OP_MARK_USED);
  assign mark_flip     = rd_data_r[page_r[4:0]] != mark_tgt;
  assign mark_word     = mark_tgt ? (rd_data_r | mark_onehot) : (rd_data_r & ~mark_onehot);

  assign in_load  = cmd.in_ready && in_ch.valid;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.alloc_addr = out_addr_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.used_count = out_count_r;

  always_comb begin
    sts           = '0;
    sts.in_valid  = in_ch.valid;
    sts.clr_last  = (clr_ptr_r == WADDR_W'(WORDS - 1));
    sts.op        = op_r;
    sts.lim_zero  = (lim == '0);
    sts.in_range  = (page_r < lim_ext);
    sts.found     = (free_bits != 32'd0);
    sts.scan_last = (chk_ext == ((lim_ext - CMP_W'(1)) >> 5));
    sts.out_free  = out_free;
  end

  // memory port selection
  always_comb begin
    we = cmd.clr_write || cmd.alloc_commit || (cmd.mark_commit && mark_flip);
    if (cmd.clr_write) begin
      wa = clr_ptr_r;
      wd = '1;
    end else if (cmd.alloc_commit) begin
      wa = chk_ptr_r;
      wd = rd_data_r | (32'd1 << enc);
    end else begin
      wa = mark_word_idx;
      wd = mark_word;
    end
    re = cmd.scan_start || cmd.scan_step || cmd.mark_read;
    if (cmd.mark_read) begin
      ra = mark_word_idx;
    end else if (cmd.scan_start) begin
      ra = '0;
    end else begin
      ra = iss_ptr_r[WADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      cfg_nxt = cfg_ch.data;
    end
    clr_ptr_nxt = clr_ptr_r;
    if (cmd.clr_write) begin
      clr_ptr_nxt = clr_ptr_r + WADDR_W'(1);
    end
    count_nxt = count_r;
    if (cmd.alloc_commit || (cmd.mark_commit && mark_flip && mark_tgt)) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.mark_commit && mark_flip) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= bpa_pkg::CFG_RESET;
      count_r     <= CNT_W'(MAX_FRAMES);
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      count_r     <= count_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      op_r   <= in_ch.op;
      page_r <= CMP_W'(in_ch.req_addr >> PAGE_SHIFT);
    end
    if (cmd.scan_start) begin
      iss_ptr_r <= (WADDR_W + 1)'(1);
      chk_ptr_r <= '0;
    end else if (cmd.scan_step) begin
      iss_ptr_r <= iss_ptr_r + (WADDR_W + 1)'(1);
      chk_ptr_r <= iss_ptr_r[WADDR_W-1:0];
    end
    if (cmd.alloc_commit) begin
      res_addr_r <= alloc_wide[bpa_pkg::ADDR_W-1:0];
      res_ok_r   <= 1'b1;
    end else if (cmd.mark_commit) begin
      res_addr_r <= '0;
      res_ok_r   <= mark_flip;
    end else if (cmd.res_fail) begin
      res_addr_r <= '0;
      res_ok_r   <= 1'b0;
    end
    if (cmd.out_load) begin
      out_addr_r  <= res_addr_r;
      out_ok_r    <= res_ok_r;
      out_count_r <= bpa_pkg::COUNT_W'(count_r);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FRAMES))
    else $error("used count above frame count");

  a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_commit |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("alloc did not bump used count");

  a_alloc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_commit |-> (CMP_W'(alloc_frame) < lim_ext) && !rd_data_r[enc])
    else $error("alloc picked a used frame or one beyond the limit");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !cmd.out_load)
    else $error("result overwritten while waiting");

endmodule

@@ src/bitmap_page_allocator_top.sv @@
// Bitmap page frame allocator, first fit.
// Channels: in_ch takes request words (op, req_addr); out_ch returns one
// result word per request (alloc_addr, ok, used_count); cfg_ch writes the
// frame limit register at any edge with valid high (ready is always high).
// After reset the bitmap is swept to all-used, one 32-frame word per cycle,
// over ceil(MAX_FRAMES/32) words (1024 by default), while in_ch.ready is low.
// A mark passes START (word read), MARK (word write) and DONE; a request
// that fails at once (page beyond the limit, zero limit, unused op) goes
// from START straight to DONE; an alloc checks bitmap words up to the first
// free one (at most ceil(limit/32)), one word per cycle from the bitmap
// memory read port, then goes to DONE. The next request is taken once the
// result is in the output register, at the earliest in the same cycle as
// valid rises; a stalled receiver holds that result, and a further request
// finishes its work and then waits until the output register frees.
// Depends on bpa_pkg, bpa_if, bpa_ctrl, bpa_datapath.
module bitmap_page_allocator_top #(
  parameter int MAX_FRAMES = bpa_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bpa_in_if.sink    in_ch,
  bpa_out_if.source out_ch,
  bpa_cfg_if.sink   cfg_ch
);

  bpa_pkg::dp_cmd_t cmd;
  bpa_pkg::dp_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  bpa_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
